@@ design/integer_to_base_ascii_unit_assert.svh @@
// assertion macros shared by the conversion unit and its divider
`ifndef INTEGER_TO_BASE_ASCII_UNIT_ASSERT_SVH
`define INTEGER_TO_BASE_ASCII_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define ITOA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ITOA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ITOA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ITOA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ design/itoa_pkg.sv @@
package itoa_pkg;

	// widths fixed by the field definitions
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int RADIX_W         = 6;
	localparam int DIGIT_W         = 6;
	localparam int CHAR_W          = 7;

	// accepted radix range
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_NONE        = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_MINUS       = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO        = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 7'h57;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN       = 6'd10;

	// status from the serial divider, one digit per division
	typedef struct packed {
		logic               dig_valid;
		logic               dig_final;
		logic [DIGIT_W-1:0] dig;
	} div_stat_t;

	// digit value to lower-case ascii
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] base;
		base = (d < DIGIT_TEN) ? CHAR_ZERO : CHAR_LETTER_BASE;
		return base + CHAR_W'(d);
	endfunction

endpackage

@@ design/itoa_serial_div.sv @@
`include "integer_to_base_ascii_unit_assert.svh"

module itoa_serial_div #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [VALUE_WIDTH-1:0]       mag,
	input  logic [itoa_pkg::RADIX_W-1:0] radix,
	output itoa_pkg::div_stat_t          stat
);

	localparam int BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_WIDTH - 1);

	logic                           busy_q;
	logic                           qnz_q;
	logic [BIT_W-1:0]               bitcnt_q;
	logic [VALUE_WIDTH-1:0]         mag_q;
	logic [itoa_pkg::DIGIT_W-1:0]   rem_q;
	logic [itoa_pkg::RADIX_W-1:0]   radix_q;

	logic [itoa_pkg::DIGIT_W:0]     trial;
	logic [itoa_pkg::DIGIT_W:0]     diff;
	logic                           ge;
	logic                           last_bit;
	logic [itoa_pkg::DIGIT_W-1:0]   rem_n;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, mag_q[VALUE_WIDTH-1]};
		diff     = trial - {1'b0, radix_q};
		ge       = trial >= {1'b0, radix_q};
		rem_n    = ge ? diff[itoa_pkg::DIGIT_W-1:0] : trial[itoa_pkg::DIGIT_W-1:0];
		last_bit = bitcnt_q == BIT_LAST;
	end

	// remainder of a finished division is the next digit, least significant first
	always_comb begin
		stat.dig_valid = busy_q && last_bit;
		stat.dig_final = !(qnz_q || ge);
		stat.dig       = rem_n;
	end

	// control: bit counter and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			qnz_q    <= 1'b0;
			bitcnt_q <= '0;
		end else if (start) begin
			busy_q   <= 1'b1;
			qnz_q    <= 1'b0;
			bitcnt_q <= '0;
		end else if (busy_q) begin
			if (last_bit) begin
				busy_q   <= qnz_q || ge;
				qnz_q    <= 1'b0;
				bitcnt_q <= '0;
			end else begin
				qnz_q    <= qnz_q || ge;
				bitcnt_q <= bitcnt_q + BIT_W'(1);
			end
		end
	end

	// datapath: dividend shifts out at the top, quotient shifts in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q   <= mag;
			radix_q <= radix;
			rem_q   <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], ge};
			rem_q <= last_bit ? '0 : rem_n;
		end
	end

	`ITOA_ASSERT_IMP(a_rem_below_radix, clk, arst_n, busy_q, rem_q < radix_q, "remainder out of range")
	`ITOA_ASSERT_IMP(a_start_when_idle, clk, arst_n, start, !busy_q, "start while dividing")
	`ITOA_ASSERT_IMP(a_digit_below_radix, clk, arst_n, stat.dig_valid, stat.dig < radix_q, "digit out of range")

endmodule

@@ design/integer_to_base_ascii_unit.sv @@
// Signed integer to ASCII digit string in radix 2 to 36.
// Request channel: req_valid/req_ready with number (VALUE_WIDTH bits, two's
// complement) and radix (6 bits). A request is taken only while the unit is
// idle; one conversion is in flight at a time.
// Result channel: res_valid/res_ready, one character per transfer, most
// significant first, a leading '-' for negative values, last on the final
// character. A radix outside 2..36 gives a single result with character 0,
// empty_res and last set.
// Each digit comes from a bit-serial restoring divide of the magnitude by
// the radix; all digits are divided out first, then the characters (sign
// included) are emitted, one character per cycle while res_ready is high.
// The next request is taken the cycle after the final character is loaded.
// An invalid radix skips the divide and goes straight to emitting.
// Reset clears the handshake and sequencing state; no result is pending.
// When the receiver stalls the result register holds its character and the
// remaining digits wait in the digit stack.
`include "integer_to_base_ascii_unit_assert.svh"

module integer_to_base_ascii_unit #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic signed [VALUE_WIDTH-1:0]       number,
	input  logic [itoa_pkg::RADIX_W-1:0]        radix,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [itoa_pkg::CHAR_W-1:0]         character,
	output logic                                empty_res,
	output logic                                last
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(VALUE_WIDTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                          state_q;
	logic                            err_q;
	logic                            sign_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [itoa_pkg::DIGIT_W-1:0]    stk_q [VALUE_WIDTH];
	logic                            res_valid_q;
	logic [itoa_pkg::CHAR_W-1:0]     char_q;
	logic                            empty_q;
	logic                            last_q;

	logic                            req_take;
	logic                            radix_ok;
	logic [VALUE_WIDTH-1:0]          num_u;
	logic [VALUE_WIDTH-1:0]          mag_in;
	logic                            div_start;
	itoa_pkg::div_stat_t             stat;
	logic                            out_free;
	logic                            emit_load;
	logic                            push;
	logic                            pop;
	logic [itoa_pkg::CHAR_W-1:0]     char_sel;
	logic                            empty_sel;
	logic                            last_sel;

	// request decode and magnitude
	always_comb begin
		req_ready = state_q == S_IDLE;
		req_take  = req_valid && req_ready;
		radix_ok  = (radix >= itoa_pkg::RADIX_MIN) && (radix <= itoa_pkg::RADIX_MAX);
		num_u     = number;
		mag_in    = num_u[VALUE_WIDTH-1] ? (~num_u + VALUE_WIDTH'(1)) : num_u;
		div_start = req_take && radix_ok;
	end

	itoa_serial_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (mag_in),
		.radix (radix),
		.stat  (stat)
	);

	// next character: error marker, sign, or top of the digit stack
	always_comb begin
		out_free  = !res_valid_q || res_ready;
		emit_load = (state_q == S_EMIT) && out_free;
		push      = stat.dig_valid;
		pop       = emit_load && !err_q && !sign_q;
		if (err_q) begin
			char_sel  = itoa_pkg::CHAR_NONE;
			empty_sel = 1'b1;
			last_sel  = 1'b1;
		end else if (sign_q) begin
			char_sel  = itoa_pkg::CHAR_MINUS;
			empty_sel = 1'b0;
			last_sel  = 1'b0;
		end else begin
			char_sel  = itoa_pkg::digit_char(stk_q[0]);
			empty_sel = 1'b0;
			last_sel  = cnt_q == CNT_ONE;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= 1'b0;
			sign_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						err_q   <= !radix_ok;
						sign_q  <= radix_ok && num_u[VALUE_WIDTH-1];
						cnt_q   <= '0;
						state_q <= radix_ok ? S_DIV : S_EMIT;
					end
				end
				S_DIV: begin
					if (push) begin
						cnt_q <= cnt_q + CNT_ONE;
						if (stat.dig_final) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						if (err_q) begin
							err_q   <= 1'b0;
							state_q <= S_IDLE;
						end else if (sign_q) begin
							sign_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - CNT_ONE;
							if (last_sel) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// digit stack: digits arrive least significant first, leave most significant first
	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= stat.dig;
			for (int i = 1; i < VALUE_WIDTH; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			char_q  <= char_sel;
			empty_q <= empty_sel;
			last_q  <= last_sel;
		end
	end

	assign res_valid = res_valid_q;
	assign character = char_q;
	assign empty_res = empty_q;
	assign last      = last_q;

	`ITOA_ASSERT_IMP(a_stack_no_overflow, clk, arst_n, push, cnt_q != CNT_FULL, "digit stack overflow")
	`ITOA_ASSERT_IMP(a_digit_only_dividing, clk, arst_n, stat.dig_valid, state_q == S_DIV, "digit outside divide")
	`ITOA_ASSERT_IMP(a_emit_has_digit, clk, arst_n, (state_q == S_EMIT) && !err_q && !sign_q, cnt_q != '0, "emit with empty stack")
	`ITOA_ASSERT_NXT(a_last_ends_item, clk, arst_n, pop && last_sel, state_q == S_IDLE, "no return to idle after last")
	`ITOA_ASSERT_IMP(a_sign_not_last, clk, arst_n, res_valid && (character == itoa_pkg::CHAR_MINUS), !last, "sign flagged last")

endmodule
